/* sv/terminal_key_event_decoder_top_macros.svh */
// Assertion helpers for the key event decoder.
// Both expect clk and arst_n in scope; reset masks the check.
`ifndef TERMINAL_KEY_EVENT_DECODER_TOP_MACROS_SVH
`define TERMINAL_KEY_EVENT_DECODER_TOP_MACROS_SVH

// Same-cycle implication
`define TKED_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tked assertion failed");

// Next-cycle implication
`define TKED_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tked assertion failed");

`endif

/* sv/tked_pkg.sv */
`default_nettype none

package tked_pkg;

	// Parser modes, one-hot
	typedef enum logic [3:0] {
		MODE_NORMAL = 4'b0001,
		MODE_ESCAPE = 4'b0010,
		MODE_CSI    = 4'b0100,
		MODE_SS3    = 4'b1000
	} mode_t;

	// Key events
	typedef enum logic [3:0] {
		KEY_NONE    = 4'd0,
		KEY_UP      = 4'd1,
		KEY_DOWN    = 4'd2,
		KEY_LEFT    = 4'd3,
		KEY_RIGHT   = 4'd4,
		KEY_PAUSE   = 4'd5,
		KEY_RESTART = 4'd6,
		KEY_BACK    = 4'd7,
		KEY_SELECT  = 4'd8
	} key_t;

	// Item kinds
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Byte codes
	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CSI = 8'h5B; // '['
	localparam logic [7:0] CH_SS3 = 8'h4F; // 'O'

	localparam int unsigned TIMEOUT_W = 16;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd35;
	localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX   = 16'hFFFF;

	// One input item
	typedef struct packed {
		logic       opcode;
		logic [7:0] byte_value;
	} item_t;

	// Final byte of an arrow sequence
	function automatic key_t direction_of(input logic [7:0] b);
		key_t k;
		case (b)
			8'h41:   k = KEY_UP;
			8'h42:   k = KEY_DOWN;
			8'h43:   k = KEY_RIGHT;
			8'h44:   k = KEY_LEFT;
			default: k = KEY_NONE;
		endcase
		return k;
	endfunction

	// Letter keys in either case
	function automatic key_t key_of_letter(input logic [7:0] b);
		logic [7:0] u;
		key_t       k;
		u = b;
		if (b >= 8'h61 && b <= 8'h7A)
			u = b - 8'h20;
		case (u)
			8'h57:   k = KEY_UP;      // W
			8'h53:   k = KEY_DOWN;    // S
			8'h41:   k = KEY_LEFT;    // A
			8'h44:   k = KEY_RIGHT;   // D
			8'h50:   k = KEY_PAUSE;   // P
			8'h52:   k = KEY_RESTART; // R
			8'h51:   k = KEY_BACK;    // Q
			default: k = KEY_NONE;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

/* sv/tked_core.sv */
`default_nettype none

`include "terminal_key_event_decoder_top_macros.svh"

module tked_core
	import tked_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [TIMEOUT_W-1:0] timeout,
	input  wire logic                 step,
	input  wire item_t                item,
	output key_t                      key
);

	mode_t                mode_q, mode_n;
	logic [TIMEOUT_W-1:0] elapsed_q, elapsed_n, elapsed_inc;
	logic                 after_ret_q, after_ret_n;
	key_t                 dir;
	logic                 esc_arm;
	logic                 tick_idle;

	assign dir = direction_of(item.byte_value);
	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + TIMEOUT_W'(1);

	// Decode one item against the parser state
	always_comb begin
		mode_n      = mode_q;
		elapsed_n   = elapsed_q;
		after_ret_n = after_ret_q;
		key         = KEY_NONE;
		if (item.opcode == OP_TICK) begin
			if (mode_q == MODE_ESCAPE) begin
				elapsed_n = elapsed_inc;
				if (elapsed_inc >= timeout) begin
					mode_n = MODE_NORMAL;
					key    = KEY_BACK;
				end
			end
		end else begin
			unique case (mode_q) inside
				MODE_ESCAPE: begin
					if (item.byte_value == CH_CSI) begin
						mode_n = MODE_CSI;
					end else if (item.byte_value == CH_SS3) begin
						mode_n = MODE_SS3;
					end else begin
						mode_n = MODE_NORMAL;
						key    = KEY_BACK;
					end
				end
				MODE_CSI, MODE_SS3: begin
					mode_n = MODE_NORMAL;
					key    = dir;
					if (dir != KEY_NONE)
						after_ret_n = 1'b0;
				end
				MODE_NORMAL: begin
					if (item.byte_value == CH_ESC) begin
						mode_n    = MODE_ESCAPE;
						elapsed_n = '0;
					end else if (item.byte_value == CH_CR) begin
						after_ret_n = 1'b1;
						key         = KEY_SELECT;
					end else if (item.byte_value == CH_LF) begin
						if (after_ret_q)
							after_ret_n = 1'b0;
						else
							key = KEY_SELECT;
					end else begin
						after_ret_n = 1'b0;
						key         = key_of_letter(item.byte_value);
					end
				end
				default: mode_n = MODE_NORMAL;
			endcase
		end
	end

	// Advance state once per decoded item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NORMAL;
			elapsed_q   <= '0;
			after_ret_q <= 1'b0;
		end else if (step) begin
			mode_q      <= mode_n;
			elapsed_q   <= elapsed_n;
			after_ret_q <= after_ret_n;
		end
	end

	// Qualifiers for the checks below
	assign esc_arm   = step && item.opcode == OP_BYTE && mode_q == MODE_NORMAL &&
		item.byte_value == CH_ESC;
	assign tick_idle = step && item.opcode == OP_TICK && mode_q != MODE_ESCAPE;

	// ESC in normal mode arms the timer from zero
	`TKED_ASSERT_NXT(a_esc_arms, esc_arm, mode_q == MODE_ESCAPE && elapsed_q == '0)
	// Ticks outside escape mode leave the state alone
	`TKED_ASSERT_NXT(a_tick_idle, tick_idle, $stable(mode_q) && $stable(elapsed_q) && $stable(after_ret_q))
	// Parser mode is always a single valid code
	`TKED_ASSERT_IMP(a_mode_onehot, 1'b1, $onehot(mode_q))

endmodule

`default_nettype wire

/* sv/terminal_key_event_decoder_top.sv */
// Channel   Dir  Payload                               Transfer
// s_*       in   tuser[0] opcode, tdata[7:0] byte      s_tvalid & s_tready
// m_*       out  tdata[3:0] key_event, [7:4] zero      m_tvalid & m_tready
// cfg_*     in   cfg_wdata escape_timeout_ticks        cfg_we
//
// One item per cycle while m_tready stays high.
// The input register feeds a single decode cone into the result register.
// Reset clears the parser to normal mode and the timeout to 35 ticks.
// A stalled output holds its result while the input register still takes one more item.
`default_nettype none

`include "terminal_key_event_decoder_top_macros.svh"

module terminal_key_event_decoder_top
	import tked_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [TIMEOUT_W-1:0] cfg_wdata,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,   // [7:0] byte_value
	input  wire logic                 s_tuser,   // [0] opcode
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [7:0]                m_tdata    // [3:0] key_event, [7:4] zero
);

	logic [TIMEOUT_W-1:0] timeout_q;
	item_t                item_s1;
	logic                 valid_s1;
	key_t                 key_s2;
	logic                 valid_s2;
	logic                 advance;
	key_t                 key;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, key_s2};

	// Hold the timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			timeout_q <= TIMEOUT_RESET;
		else if (cfg_we)
			timeout_q <= cfg_wdata;
	end

	// Capture an input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			item_s1 <= '{opcode: s_tuser, byte_value: s_tdata};
	end

	tked_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.timeout (timeout_q),
		.step    (advance),
		.item    (item_s1),
		.key     (key)
	);

	// Load the result register, drop it on an output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (m_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			key_s2 <= key;
	end

	// Input stalls only when both registers are full and output is blocked
	`TKED_ASSERT_IMP(a_stall_cause, !s_tready, valid_s1 && valid_s2 && !m_tready)
	// A decoded item always reaches the result register
	`TKED_ASSERT_NXT(a_adv_result, advance, valid_s2)
	// Result codes stay in range with the pad bits clear
	`TKED_ASSERT_IMP(a_key_range, m_tvalid, m_tdata[3:0] <= KEY_SELECT && m_tdata[7:4] == 4'b0000)
	// Ticks never yield anything but none or back
	`TKED_ASSERT_IMP(a_tick_key, advance && item_s1.opcode == OP_TICK, key == KEY_NONE || key == KEY_BACK)

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
	import tked_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // [7:0] byte_value
	logic        s_tuser   = 1'b0; // [0] opcode
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;          // [3:0] key_event, [7:4] zero

	terminal_key_event_decoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Decoder state as the testbench tracks it
	mode_t       pmode         = MODE_NORMAL;
	logic [15:0] esc_ticks     = '0;
	logic        cr_seen       = 1'b0;
	logic [15:0] timeout_ticks = TIMEOUT_RESET;

	item_t pending_items[$];
	key_t  expected_keys[$];

	int key_errors    = 0;
	int items_sent    = 0;
	int ticks_sent    = 0;
	int keys_seen     = 0;
	int timeout_backs = 0;
	int settings_used = 1;

	// Final byte of ESC [ x or ESC O x
	function automatic key_t arrow_key(input logic [7:0] b);
		key_t k;
		case (b)
			"A":     k = KEY_UP;
			"B":     k = KEY_DOWN;
			"C":     k = KEY_RIGHT;
			"D":     k = KEY_LEFT;
			default: k = KEY_NONE;
		endcase
		return k;
	endfunction

	// Letter keys, folded to upper case first
	function automatic key_t letter_key(input logic [7:0] b);
		logic [7:0] u;
		key_t       k;
		u = (b >= "a" && b <= "z") ? b - 8'h20 : b;
		case (u)
			"W":     k = KEY_UP;
			"S":     k = KEY_DOWN;
			"A":     k = KEY_LEFT;
			"D":     k = KEY_RIGHT;
			"P":     k = KEY_PAUSE;
			"R":     k = KEY_RESTART;
			"Q":     k = KEY_BACK;
			default: k = KEY_NONE;
		endcase
		return k;
	endfunction

	// Advance the tracked parser by one item and return its key event
	function key_t decode_key(input item_t it);
		key_t k;
		k = KEY_NONE;
		if (it.opcode == OP_TICK) begin
			if (pmode == MODE_ESCAPE) begin
				if (esc_ticks != ELAPSED_MAX)
					esc_ticks = esc_ticks + 16'd1;
				if (esc_ticks >= timeout_ticks) begin
					pmode = MODE_NORMAL;
					k = KEY_BACK;
					timeout_backs++;
				end
			end
		end else if (pmode == MODE_ESCAPE) begin
			if (it.byte_value == CH_CSI)
				pmode = MODE_CSI;
			else if (it.byte_value == CH_SS3)
				pmode = MODE_SS3;
			else begin
				pmode = MODE_NORMAL;
				k = KEY_BACK;
			end
		end else if (pmode == MODE_CSI || pmode == MODE_SS3) begin
			pmode = MODE_NORMAL;
			k = arrow_key(it.byte_value);
			if (k != KEY_NONE)
				cr_seen = 1'b0;
		end else if (it.byte_value == CH_ESC) begin
			pmode = MODE_ESCAPE;
			esc_ticks = '0;
		end else if (it.byte_value == CH_CR) begin
			cr_seen = 1'b1;
			k = KEY_SELECT;
		end else if (it.byte_value == CH_LF) begin
			// LF straight after CR is swallowed
			if (cr_seen)
				cr_seen = 1'b0;
			else
				k = KEY_SELECT;
		end else begin
			cr_seen = 1'b0;
			k = letter_key(it.byte_value);
		end
		return k;
	endfunction

	// Sender: bursts of random length separated by random gaps
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		item_t it;
		logic  next_valid;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				it.opcode     = s_tuser;
				it.byte_value = s_tdata;
				expected_keys.push_back(decode_key(it));
				items_sent++;
				if (s_tuser == OP_TICK)
					ticks_sent++;
			end
			// Hold the item on the bus until it transfers
			if (!(s_tvalid && !s_tready)) begin
				next_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_items.size() != 0) begin
					it = pending_items.pop_front();
					s_tuser    <= it.opcode;
					s_tdata    <= it.byte_value;
					next_valid = 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
				s_tvalid <= next_valid;
			end
		end
	end

	// Receiver: rotating stall mask, reloaded with a random value whenever mask_cycles wraps
	logic [7:0] ready_mask  = 8'hFF;
	int         mask_cycles = 0;

	always @(posedge clk or negedge arst_n) begin
		key_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				keys_seen++;
				if (expected_keys.size() == 0) begin
					$display("%0t: key event with none expected: actual %0d", $time,
						m_tdata[3:0]);
					key_errors++;
				end else begin
					want = expected_keys.pop_front();
					if (m_tdata[3:0] !== want) begin
						$display("%0t: key_event expected %0d actual %0d", $time, want,
							m_tdata[3:0]);
						key_errors++;
					end
					if (m_tdata[7:4] !== 4'h0) begin
						$display("%0t: tdata padding expected 0 actual %h", $time,
							m_tdata[7:4]);
						key_errors++;
					end
				end
			end
			mask_cycles++;
			if (mask_cycles == 64) begin
				mask_cycles = 0;
				ready_mask  = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
			end else begin
				ready_mask = {ready_mask[0], ready_mask[7:1]};
			end
			m_tready <= ready_mask[0];
		end
	end

	// Watchdog: end the run if no transfer happens for too long
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("terminal_key_event_decoder_top: mismatch");
				$finish;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		item_t it;
		it.opcode     = OP_BYTE;
		it.byte_value = b;
		pending_items.push_back(it);
	endtask

	task automatic push_ticks(input int n);
		item_t it;
		it.opcode     = OP_TICK;
		it.byte_value = 8'($urandom);
		for (int i = 0; i < n; i++) begin
			pending_items.push_back(it);
			it.byte_value = 8'($urandom);
		end
	endtask

	// Wait until everything sent has come back out; sample between edges
	task automatic drain();
		while (pending_items.size() != 0 || s_tvalid || expected_keys.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we        <= 1'b0;
		timeout_ticks = v;
		settings_used++;
	endtask

	// Mostly well-formed key sequences with random content, plus noise
	task automatic push_random(input int count);
		string letters;
		int    start;
		int    n;
		letters = "wsadprqWSADPRQ";
		start   = pending_items.size();
		while (pending_items.size() - start < count) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					push_byte(CH_ESC);
					push_byte($urandom_range(0, 1) ? CH_CSI : CH_SS3);
					if ($urandom_range(0, 9) < 7)
						push_byte(8'("A") + 8'($urandom_range(0, 3)));
					else
						push_byte(8'($urandom));
				end
				2: begin
					push_byte(CH_ESC);
					push_byte(8'($urandom));
				end
				3: begin
					push_byte(CH_ESC);
					n = (timeout_ticks < 6) ? int'(timeout_ticks) + 2 : 6;
					push_ticks($urandom_range(0, n));
					if ($urandom_range(0, 1))
						push_byte(8'($urandom));
				end
				4: begin
					push_byte(CH_CR);
					push_byte(($urandom_range(0, 9) < 7) ? CH_LF : 8'($urandom));
				end
				5: push_byte(letters[$urandom_range(0, letters.len() - 1)]);
				6: push_byte(8'($urandom));
				7: push_ticks($urandom_range(1, 3));
				8: push_byte(CH_LF);
				default: begin
					push_byte(8'($urandom));
					push_byte($urandom_range(0, 1) ? CH_ESC : 8'($urandom));
				end
			endcase
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: CR/LF pairing, arrows both ways, BACK paths, letters, extremes
		push_byte(CH_CR);  push_byte(CH_LF);  push_byte(CH_LF);
		push_byte(CH_ESC); push_byte(CH_CSI); push_byte("A");
		push_byte(CH_ESC); push_byte(CH_SS3); push_byte("D");
		push_byte(CH_ESC); push_byte("x");
		push_byte(CH_ESC); push_byte(CH_ESC);
		push_byte(CH_ESC); push_byte(CH_CSI); push_byte("z");
		push_byte("w");    push_byte("Q");    push_byte("p");    push_byte("R");
		push_byte(8'h00);  push_byte(8'hFF);  push_ticks(1);
		push_byte(CH_CR);  push_byte(CH_ESC); push_byte(CH_SS3); push_byte("C");
		push_byte(CH_LF);
		// Leave the parser in escape mode with a few ticks counted
		push_byte(CH_ESC); push_ticks(5);
		drain();

		// Lower the timeout below the count: the next byte still parses
		write_timeout(16'd2);
		push_byte(CH_CSI); push_byte("B");
		push_byte(CH_ESC); push_ticks(3);
		push_random(70);
		drain();

		write_timeout(16'd0);
		push_byte(CH_ESC); push_ticks(2);
		push_random(70);
		drain();

		write_timeout(16'd1);
		push_random(70);
		drain();

		// Largest timeout: a lone ESC outlasts a run of ticks, then a byte follows it
		write_timeout(16'hFFFF);
		push_byte(CH_ESC); push_ticks(20); push_byte("x");
		push_random(50);
		drain();

		write_timeout(16'($urandom_range(3, 12)));
		push_random(65);
		drain();

		write_timeout(TIMEOUT_RESET);
		push_random(65);
		drain();

		$display("run covered %0d items (%0d ticks) and %0d key events", items_sent,
			ticks_sent, keys_seen);
		$display("over %0d timeout settings, with %0d lone escapes timing out",
			settings_used, timeout_backs);
		if (key_errors == 0)
			$display("terminal_key_event_decoder_top: match");
		else
			$display("terminal_key_event_decoder_top: mismatch");
		$finish;
	end

endmodule
